/* hdl/avi_pkg.sv */
`default_nettype none
package avi_pkg;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
  } sample_t;

  typedef struct packed {
    logic signed [32:0] net_accel;
    logic signed [47:0] velocity;
    logic signed [47:0] position;
    logic [1:0]         motion_dir;
  } result_t;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP     = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_DEAD    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_VELOCITY_DEAD = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY       = 2'd3;

  localparam logic [15:0] TIME_STEP_RESET     = 16'd655;
  localparam logic [14:0] ACCEL_DEAD_RESET    = 15'd10;
  localparam logic [31:0] VELOCITY_DEAD_RESET = 32'd393216;
  localparam logic [11:0] GRAVITY_RESET       = 12'd1000;

  localparam logic [1:0] DIR_STILL = 2'd0;
  localparam logic [1:0] DIR_UP    = 2'd1;
  localparam logic [1:0] DIR_DOWN  = 2'd2;

  // trapezoid: sum width, time step width, product >> 17 (q0.16 step and halving)
  localparam int SUM_W      = 50;
  localparam int STEP_W     = 16;
  localparam int TRAP_SHIFT = 17;

  localparam logic signed [SUM_W-1:0] ACC_MAX = 50'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] ACC_MIN = -50'sh8000_0000_0000;

endpackage
`default_nettype wire

/* hdl/accel_velocity_integrator.sv */
// flow: bit-serial squarers, root and divider run in turn from the sample beat to the
//   result, then two serial trapezoid multiplies; a sample in the acceleration dead
//   zone skips the trapezoid multiplies
// samples: one at a time; a new sample is taken only once the last result is in the
//   output register, where a finished result may wait while the next sample is taken
// reset: clears the integrator state to zero and loads the register defaults
`default_nettype none
module accel_velocity_integrator #(
  parameter int FRAC_BITS = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_ready,
  input  avi_pkg::sample_t               sample,
  output logic                           result_valid,
  input  logic                           result_ready,
  output avi_pkg::result_t               result,
  input  logic                           cfg_we,
  input  logic [avi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [avi_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import avi_pkg::*;

  localparam int EW   = FRAC_BITS + 12;
  localparam int NUMW = FRAC_BITS + 35;
  localparam int WW   = (FRAC_BITS + 18 > 40) ? FRAC_BITS + 18 : 40;
  localparam int PW   = SUM_W + STEP_W;
  localparam int TW   = PW - TRAP_SHIFT;

  localparam logic signed [WW-1:0] NET_MAX = WW'(33'shFFFF_FFFF);
  localparam logic signed [WW-1:0] NET_MIN = -NET_MAX - WW'(1);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_MUL  = 9'b000000010,
    S_ROOT = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_NET  = 9'b000010000,
    S_TRV  = 9'b000100000,
    S_VEL  = 9'b001000000,
    S_TRP  = 9'b010000000,
    S_POS  = 9'b100000000
  } state_t;

  function automatic logic signed [47:0] sat48(input logic signed [SUM_W-1:0] v);
    if (v > ACC_MAX) begin
      return ACC_MAX[47:0];
    end else if (v < ACC_MIN) begin
      return ACC_MIN[47:0];
    end
    return v[47:0];
  endfunction

  state_t state;

  logic [15:0] time_step;
  logic [14:0] accel_dead_zone;
  logic [31:0] velocity_dead_zone;
  logic [11:0] gravity_mg;

  logic signed [32:0] prev_accel;
  logic signed [47:0] prev_velocity;
  logic signed [47:0] prev_position;

  logic signed [15:0] z_r;
  logic               mag_zero;
  logic signed [32:0] net_r;
  logic signed [47:0] v_r;
  logic signed [47:0] p_r;

  logic [15:0] abs_x;
  logic [15:0] abs_y;
  logic [15:0] abs_z;
  logic        accept;

  logic signed [32:0] sq_x;
  logic signed [32:0] sq_y;
  logic signed [32:0] sq_z;
  logic signed [28:0] gz_prod;
  logic               sq_done;
  logic [31:0]        mag2;

  logic [23:0]   root;
  logic          root_done;
  logic [NUMW-1:0] dividend;
  logic [EW-1:0] quotient;
  logic          div_done;

  logic signed [WW-1:0] z_w;
  logic signed [WW-1:0] est_w;
  logic signed [WW-1:0] est_s;
  logic signed [WW-1:0] diff;
  logic signed [32:0]   net_c;
  logic signed [WW-1:0] net_w;
  logic signed [WW-1:0] adz_w;
  logic                 in_dz;

  logic signed [SUM_W-1:0] sum_a;
  logic signed [SUM_W-1:0] sum_v;
  logic signed [SUM_W-1:0] trap_a;
  logic                    trap_start;
  logic                    trap_done;
  logic signed [PW-1:0]    trap_prod;
  logic signed [TW-1:0]    trap_term;
  logic signed [SUM_W-1:0] v_sum;
  logic signed [SUM_W-1:0] p_sum;
  logic signed [47:0]      v_c;
  logic signed [48:0]      v_w;
  logic signed [48:0]      vdz_w;
  logic                    v_dz;

  assign sample_ready = (state == S_IDLE);
  assign accept       = sample_valid && sample_ready;

  assign abs_x = sample.accel_x[15] ? 16'(-sample.accel_x) : 16'(sample.accel_x);
  assign abs_y = sample.accel_y[15] ? 16'(-sample.accel_y) : 16'(sample.accel_y);
  assign abs_z = sample.accel_z[15] ? 16'(-sample.accel_z) : 16'(sample.accel_z);

  // squares and gravity * |z| run side by side
  avi_smul #(.AW(17), .BW(16)) u_sq_x (
    .clk(clk), .rst(rst), .start(accept),
    .a(signed'({1'b0, abs_x})), .b(abs_x), .done(sq_done), .product(sq_x)
  );

  avi_smul #(.AW(17), .BW(16)) u_sq_y (
    .clk(clk), .rst(rst), .start(accept),
    .a(signed'({1'b0, abs_y})), .b(abs_y), .done(), .product(sq_y)
  );

  avi_smul #(.AW(17), .BW(16)) u_sq_z (
    .clk(clk), .rst(rst), .start(accept),
    .a(signed'({1'b0, abs_z})), .b(abs_z), .done(), .product(sq_z)
  );

  avi_smul #(.AW(13), .BW(16)) u_grav (
    .clk(clk), .rst(rst), .start(accept),
    .a(signed'({1'b0, gravity_mg})), .b(abs_z), .done(), .product(gz_prod)
  );

  assign mag2 = sq_x[31:0] + sq_y[31:0] + sq_z[31:0];

  // magnitude with 8 fraction bits
  avi_sqrt #(.RW(48)) u_sqrt (
    .clk(clk), .rst(rst), .start((state == S_MUL) && sq_done),
    .radicand({mag2, 16'h0000}), .done(root_done), .root(root)
  );

  assign dividend = {gz_prod[26:0], (FRAC_BITS + 8)'(0)};

  avi_div #(.NW(NUMW), .DW(24), .QW(EW)) u_div (
    .clk(clk), .rst(rst), .start((state == S_ROOT) && root_done),
    .dividend(dividend), .divisor(root), .done(div_done), .quotient(quotient)
  );

  // gravity removal and acceleration dead zone
  assign z_w   = WW'(z_r) <<< FRAC_BITS;
  assign est_w = mag_zero ? '0 : signed'(WW'(quotient));
  assign est_s = z_r[15] ? -est_w : est_w;
  assign diff  = z_w - est_s;

  always_comb begin
    if (diff > NET_MAX) begin
      net_c = NET_MAX[32:0];
    end else if (diff < NET_MIN) begin
      net_c = NET_MIN[32:0];
    end else begin
      net_c = diff[32:0];
    end
  end

  assign net_w = WW'(net_c);
  assign adz_w = signed'(WW'(accel_dead_zone) << FRAC_BITS);
  assign in_dz = (net_w >= -adz_w) && (net_w <= adz_w);

  // trapezoid terms share one serial multiplier
  assign sum_a      = SUM_W'(prev_accel) + SUM_W'(net_c);
  assign sum_v      = SUM_W'(prev_velocity) + SUM_W'(v_r);
  assign trap_a     = (state == S_NET) ? sum_a : sum_v;
  assign trap_start = ((state == S_NET) && !in_dz) || (state == S_VEL);

  avi_smul #(.AW(SUM_W), .BW(STEP_W)) u_trap (
    .clk(clk), .rst(rst), .start(trap_start),
    .a(trap_a), .b(time_step), .done(trap_done), .product(trap_prod)
  );

  assign trap_term = trap_prod[PW-1:TRAP_SHIFT];
  assign v_sum     = SUM_W'(prev_velocity) + SUM_W'(trap_term);
  assign p_sum     = SUM_W'(prev_position) + SUM_W'(trap_term);
  assign v_c       = sat48(v_sum);
  assign v_w       = 49'(v_c);
  assign vdz_w     = signed'(49'(velocity_dead_zone));
  assign v_dz      = (v_w >= -vdz_w) && (v_w <= vdz_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_step          <= TIME_STEP_RESET;
      accel_dead_zone    <= ACCEL_DEAD_RESET;
      velocity_dead_zone <= VELOCITY_DEAD_RESET;
      gravity_mg         <= GRAVITY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_STEP:     time_step          <= cfg_data[15:0];
        REG_ACCEL_DEAD:    accel_dead_zone    <= cfg_data[14:0];
        REG_VELOCITY_DEAD: velocity_dead_zone <= cfg_data[31:0];
        REG_GRAVITY:       gravity_mg         <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      result_valid  <= 1'b0;
      prev_accel    <= '0;
      prev_velocity <= '0;
      prev_position <= '0;
    end else begin
      if (result_valid && result_ready && (state != S_POS)) begin
        result_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_MUL;
          end
        end
        S_MUL: begin
          if (sq_done) begin
            state <= S_ROOT;
          end
        end
        S_ROOT: begin
          if (root_done) begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_NET;
          end
        end
        S_NET: begin
          if (in_dz) begin
            state <= S_POS;
          end else begin
            state <= S_TRV;
          end
        end
        S_TRV: begin
          if (trap_done) begin
            state <= S_VEL;
          end
        end
        S_VEL: begin
          state <= S_TRP;
        end
        S_TRP: begin
          if (trap_done) begin
            state <= S_POS;
          end
        end
        S_POS: begin
          if (!result_valid || result_ready) begin
            result_valid  <= 1'b1;
            prev_accel    <= net_r;
            prev_velocity <= v_r;
            prev_position <= p_r;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      z_r <= sample.accel_z;
    end
    if ((state == S_ROOT) && root_done) begin
      mag_zero <= (root == '0);
    end
    if (state == S_NET) begin
      if (in_dz) begin
        net_r <= '0;
        v_r   <= '0;
        p_r   <= prev_position;
      end else begin
        net_r <= net_c;
      end
    end
    if ((state == S_TRV) && trap_done) begin
      v_r <= v_dz ? '0 : v_c;
    end
    if ((state == S_TRP) && trap_done) begin
      p_r <= sat48(p_sum);
    end
    if ((state == S_POS) && (!result_valid || result_ready)) begin
      result.net_accel <= net_r;
      result.velocity  <= v_r;
      result.position  <= p_r;
      if (v_r == '0) begin
        result.motion_dir <= DIR_STILL;
      end else if (v_r[47]) begin
        result.motion_dir <= DIR_UP;
      end else begin
        result.motion_dir <= DIR_DOWN;
      end
    end
  end

endmodule
`default_nettype wire

/* hdl/avi_smul.sv */
`default_nettype none
module avi_smul #(
  parameter int AW = 17,
  parameter int BW = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic signed [AW-1:0]     a,
  input  logic [BW-1:0]            b,
  output logic                     done,
  output logic signed [AW+BW-1:0]  product
);

  localparam int CW = $clog2(BW + 1);

  logic signed [AW-1:0]    a_hold;
  logic [BW-1:0]           b_sh;
  logic [CW-1:0]           count;
  logic                    busy;
  logic signed [AW+BW-1:0] addend;

  // one bit of b per cycle, msb first
  assign addend = b_sh[BW-1] ? (AW+BW)'(a_hold) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(BW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_hold  <= a;
      b_sh    <= b;
      product <= '0;
    end else if (busy) begin
      product <= {product[AW+BW-2:0], 1'b0} + addend;
      b_sh    <= {b_sh[BW-2:0], 1'b0};
    end
  end

endmodule
`default_nettype wire

/* hdl/avi_sqrt.sv */
`default_nettype none
module avi_sqrt #(
  parameter int RW = 48
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [RW-1:0]   radicand,
  output logic            done,
  output logic [RW/2-1:0] root
);

  localparam int RH = RW / 2;
  localparam int CW = $clog2(RH + 1);

  logic [RW-1:0] rad_sh;
  logic [RH:0]   rem;
  logic [CW-1:0] count;
  logic          busy;
  logic [RH+2:0] trial_rem;
  logic [RH+2:0] trial;
  logic          fits;

  // two radicand bits in, one root bit out per cycle
  assign trial_rem = {rem, rad_sh[RW-1:RW-2]};
  assign trial     = {1'b0, root, 2'b01};
  assign fits      = trial_rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(RH);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_sh <= radicand;
      rem    <= '0;
      root   <= '0;
    end else if (busy) begin
      rad_sh <= {rad_sh[RW-3:0], 2'b00};
      if (fits) begin
        rem <= (RH+1)'(trial_rem - trial);
      end else begin
        rem <= trial_rem[RH:0];
      end
      root <= {root[RH-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* hdl/avi_div.sv */
`default_nettype none
module avi_div #(
  parameter int NW = 51,
  parameter int DW = 24,
  parameter int QW = 28
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [NW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          done,
  output logic [QW-1:0] quotient
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [DW-1:0] div_hold;
  logic [QW-1:0] lo_sh;
  logic [CW-1:0] count;
  logic          busy;
  logic [DW:0]   trial;
  logic          fits;

  // restoring division, one quotient bit per cycle; the quotient is known to fit QW bits
  assign trial = {rem, lo_sh[QW-1]};
  assign fits  = trial >= {1'b0, div_hold};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= CW'(QW);
      end else if (busy) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= DW'(dividend[NW-1:QW]);
      lo_sh    <= dividend[QW-1:0];
      div_hold <= divisor;
      quotient <= '0;
    end else if (busy) begin
      if (fits) begin
        rem <= DW'(trial - {1'b0, div_hold});
      end else begin
        rem <= trial[DW-1:0];
      end
      lo_sh    <= {lo_sh[QW-2:0], 1'b0};
      quotient <= {quotient[QW-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* sim/avi_checker.sv */
`default_nettype none
module avi_checker #(
  parameter int FRAC_BITS = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            sample_valid,
  input  wire logic                            sample_ready,
  input  wire avi_pkg::sample_t                sample,
  input  wire logic                            result_valid,
  input  wire logic                            result_ready,
  input  wire avi_pkg::result_t                result,
  input  wire logic                            cfg_we,
  input  wire logic [avi_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [avi_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   fails,
  output int                                   pending
);

  import avi_pkg::*;

  localparam longint KIN_MAX = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint KIN_MIN = -KIN_MAX - 1;
  localparam longint NET_MAX = 64'sh0000_0000_FFFF_FFFF;
  localparam longint NET_MIN = -NET_MAX - 1;

  logic [15:0] time_step;
  logic [14:0] accel_zone;
  logic [31:0] vel_zone;
  logic [11:0] gravity;

  longint kept_accel;
  longint kept_velocity;
  longint kept_position;

  result_t motion_q[$];
  result_t want;
  int      fail_count = 0;

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned root, bitv, rem;
    root = 0;
    rem  = n;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem  = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  // floor(s * dt / 2^17), kept wide so the product cannot overflow
  function automatic longint trapezoid_area(input longint s, input logic [15:0] dt);
    logic signed [127:0] wide;
    wide = s;
    wide = wide * $signed({112'd0, dt});
    wide = wide >>> 17;
    return wide[63:0];
  endfunction

  function automatic result_t integrate_sample(input sample_t s);
    longint          ax, ay, az, est, net, vel, pos, zone_a, zone_v;
    longint unsigned mag, num;
    result_t         r;
    ax = $signed(s.accel_x);
    ay = $signed(s.accel_y);
    az = $signed(s.accel_z);
    mag = floor_sqrt(longint'(ax * ax + ay * ay + az * az) << 16);
    est = 0;
    if (mag != 0) begin
      num = (longint'(gravity) * (az < 0 ? -az : az)) << (FRAC_BITS + 8);
      est = longint'(num / mag);
      if (az < 0) est = -est;
    end
    net = clip(az * (64'sd1 <<< FRAC_BITS) - est, NET_MIN, NET_MAX);
    zone_a = longint'(accel_zone) <<< FRAC_BITS;
    zone_v = longint'(vel_zone);
    if (net >= -zone_a && net <= zone_a) begin
      // still: forget motion, hold where we are
      net = 0;
      kept_velocity = 0;
      vel = 0;
      pos = kept_position;
    end else begin
      vel = clip(kept_velocity + trapezoid_area(kept_accel + net, time_step),
                 KIN_MIN, KIN_MAX);
      if (vel >= -zone_v && vel <= zone_v) vel = 0;
      pos = clip(kept_position + trapezoid_area(kept_velocity + vel, time_step),
                 KIN_MIN, KIN_MAX);
    end
    kept_accel    = net;
    kept_velocity = vel;
    kept_position = pos;
    r.net_accel  = net[32:0];
    r.velocity   = vel[47:0];
    r.position   = pos[47:0];
    r.motion_dir = vel == 0 ? DIR_STILL : (vel < 0 ? DIR_UP : DIR_DOWN);
    return r;
  endfunction

  task automatic flag_field(input string field, input logic [47:0] exp_v,
                            input logic [47:0] got_v);
    $display("%0t: %s expected %h got %h", $time, field, exp_v, got_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      time_step     = TIME_STEP_RESET;
      accel_zone    = ACCEL_DEAD_RESET;
      vel_zone      = VELOCITY_DEAD_RESET;
      gravity       = GRAVITY_RESET;
      kept_accel    = 0;
      kept_velocity = 0;
      kept_position = 0;
      motion_q.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (motion_q.size() == 0) begin
          $display("%0t: result beat with none expected, got %h", $time, result);
          fail_count++;
        end else begin
          want = motion_q.pop_front();
          if (result.net_accel !== want.net_accel)
            flag_field("net_accel", 48'(want.net_accel), 48'(result.net_accel));
          if (result.velocity !== want.velocity)
            flag_field("velocity", want.velocity, result.velocity);
          if (result.position !== want.position)
            flag_field("position", want.position, result.position);
          if (result.motion_dir !== want.motion_dir)
            flag_field("motion_dir", 48'(want.motion_dir), 48'(result.motion_dir));
        end
      end
      if (sample_valid && sample_ready) motion_q.push_back(integrate_sample(sample));
      if (cfg_we) begin
        case (cfg_index)
          REG_TIME_STEP:     time_step  = cfg_data[15:0];
          REG_ACCEL_DEAD:    accel_zone = cfg_data[14:0];
          REG_VELOCITY_DEAD: vel_zone   = cfg_data[31:0];
          REG_GRAVITY:       gravity    = cfg_data[11:0];
          default: ;
        endcase
      end
    end
    fails   <= fail_count;
    pending <= motion_q.size();
  end

endmodule
`default_nettype wire

/* sim/tb.sv */
`default_nettype none
module tb;
  import avi_pkg::*;

  localparam int FRAC = 16;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   sample_valid = 1'b0;
  logic                   sample_ready;
  sample_t                sample = '0;
  logic                   result_valid;
  logic                   result_ready = 1'b0;
  result_t                result;
  logic                   cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = REG_TIME_STEP;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  int                     fails;
  int                     pending;

  int          beat_count = 0;
  int          send_idle = 12;
  int          recv_idle = 67;
  logic [11:0] cur_g = GRAVITY_RESET;

  accel_velocity_integrator #(.FRAC_BITS(FRAC)) dut (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  avi_checker #(.FRAC_BITS(FRAC)) chk (
    .clk(clk), .rst(rst),
    .sample_valid(sample_valid), .sample_ready(sample_ready), .sample(sample),
    .result_valid(result_valid), .result_ready(result_ready), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fails(fails), .pending(pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) result_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send_sample(input logic [15:0] xv, input logic [15:0] yv,
                             input logic [15:0] zv);
    beat_count++;
    if (beat_count == 380) begin
      send_idle = 67;
      recv_idle = 12;
    end else if (beat_count == 760) begin
      send_idle = 0;
      recv_idle = 0;
    end
    while ($urandom_range(99) < send_idle) begin
      sample_valid <= 1'b0;
      @(posedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= '{accel_x: xv, accel_y: yv, accel_z: zv};
    @(posedge clk);
    while (!sample_ready) @(posedge clk);
  endtask

  task automatic drain();
    sample_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // upper data bits of the narrower registers carry junk, the block keeps only the register width
  task automatic load_regs(input logic [15:0] ts, input logic [14:0] adz,
                           input logic [31:0] vdz, input logic [11:0] grav);
    logic [31:0] junk;
    drain();
    junk = $urandom();
    cfg_we    <= 1'b1;
    cfg_index <= REG_TIME_STEP;
    cfg_data  <= {junk[31:16], ts};
    @(posedge clk);
    cfg_index <= REG_ACCEL_DEAD;
    cfg_data  <= {junk[31:15], adz};
    @(posedge clk);
    cfg_index <= REG_VELOCITY_DEAD;
    cfg_data  <= vdz;
    @(posedge clk);
    cfg_index <= REG_GRAVITY;
    cfg_data  <= {junk[31:12], grav};
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_g = grav;
  endtask

  function automatic logic [15:0] corner_value();
    case ($urandom_range(4))
      0:       return 16'h8000;
      1:       return 16'hFFFF;
      2:       return 16'h0000;
      3:       return 16'h0001;
      default: return 16'h7FFF;
    endcase
  endfunction

  // mostly a sensor near rest or moving along z, the rest raw noise and corners
  task automatic run_random(input int count, input bit climb);
    int          r, spread, zv;
    logic [15:0] xv, yv, zq;
    repeat (count) begin
      r = $urandom_range(99);
      if (climb) begin
        xv = 16'($urandom_range(600) - 300);
        yv = 16'($urandom_range(600) - 300);
        zq = 16'($urandom_range(32767, 30000));
      end else if (r < 55) begin
        xv = 16'($urandom_range(600) - 300);
        yv = 16'($urandom_range(600) - 300);
        spread = ($urandom_range(3) == 0) ? 2000 : 40;
        zv = int'(cur_g) + int'($urandom_range(2 * spread)) - spread;
        if ($urandom_range(1)) zv = -zv;
        if (zv > 32767) zv = 32767;
        if (zv < -32768) zv = -32768;
        zq = 16'(zv);
      end else if (r < 85) begin
        xv = 16'($urandom());
        yv = 16'($urandom());
        zq = 16'($urandom());
      end else begin
        xv = corner_value();
        yv = corner_value();
        zq = corner_value();
      end
      send_sample(xv, yv, zq);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    send_sample(0, 0, 0);
    send_sample(0, 0, 1000);
    send_sample(0, 0, -1000);
    send_sample(0, 0, 1010);
    send_sample(0, 0, 1011);
    send_sample(0, 0, 5000);
    send_sample(0, 0, 5000);
    send_sample(0, 0, -1010);
    send_sample(0, 0, -1011);
    send_sample(0, 0, -3000);
    send_sample(300, -400, 1000);
    send_sample(32767, 32767, 32767);
    send_sample(-32768, -32768, -32768);
    send_sample(-32768, 0, 0);
    send_sample(0, 32767, 0);
    send_sample(0, 0, 32767);
    send_sample(0, 0, -32768);
    send_sample(32767, -32768, 1);
    send_sample(1, 1, -1);
    send_sample(0, 0, 1000);

    load_regs(16'hFFFF, 15'd0, 32'd0, 12'd4000);
    run_random(150, 1'b0);
    load_regs(16'd1, 15'h7FFF, 32'hFFFF_FFFF, 12'd1);
    run_random(80, 1'b0);
    repeat (3) begin
      load_regs(16'($urandom_range(65535, 1)), 15'($urandom_range(200)),
                $urandom() >> $urandom_range(31), 12'($urandom_range(4095, 1)));
      run_random(100, 1'b0);
    end
    // long climb so the position reaches its limit
    load_regs(16'hFFFF, 15'd0, 32'd0, 12'd1);
    run_random(420, 1'b1);
    load_regs(16'd0, 15'd10, 32'd393216, 12'd0);
    run_random(60, 1'b0);
    load_regs(TIME_STEP_RESET, ACCEL_DEAD_RESET, VELOCITY_DEAD_RESET, GRAVITY_RESET);
    run_random(100, 1'b0);

    drain();
    repeat (120) @(posedge clk);
    if (fails == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire

/* accel_velocity_integrator.f */
hdl/avi_pkg.sv
hdl/avi_smul.sv
hdl/avi_sqrt.sv
hdl/avi_div.sv
hdl/accel_velocity_integrator.sv
sim/avi_checker.sv
sim/tb.sv
